[rtl/core/gbft_pkg.sv]
`default_nettype none

package gbft_pkg;

	// Graph size limits
	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;

	// Field widths of the channels
	localparam int NODE_W = 6;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	// Derived widths: node index, edge index, edge count, queue pointer
	localparam int NI_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W = $clog2(MAX_EDGES + 1);
	localparam int QP_W = $clog2(MAX_NODES + 1);

	// Function codes of an input item
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD      = 2'd0,
		FUNC_TRAVERSE = 2'd1,
		FUNC_CLEAR    = 2'd2
	} func_t;

	// Status codes of a result
	typedef enum logic [STAT_W-1:0] {
		STAT_VISIT   = 2'd0,
		STAT_STORED  = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_CLEARED = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic add;
		logic clear;
		logic trav_start;
		logic fetch;
		logic load;
		logic scan;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic start_ok;
		logic scan_done;
		logic queue_empty;
	} dp_status_t;

endpackage

`default_nettype wire

[rtl/core/graph_breadth_first_traversal_unit.sv]
`default_nettype none
// Channel   Handshake          Fields
// command   start & !busy      func, node_a, node_b
// result    strobe (1 cycle)   node, status, last
//
// Add and clear: result in the cycle after the transfer, busy stays low.
// Traverse: each dequeued node rescans the edge table through its single
// read port, one edge per cycle.
// Reset clears edge count, visited marks and queue pointers at once; the
// edge table and queue are not cleared. Results cannot be held off.

module graph_breadth_first_traversal_unit (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  [gbft_pkg::FUNC_W-1:0]     func,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_a,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_b,
	output logic                            strobe,
	output logic [gbft_pkg::NODE_W-1:0]     node,
	output logic [gbft_pkg::STAT_W-1:0]     status,
	output logic                            last
);
	import gbft_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	gbft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	gbft_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.node_a (node_a),
		.node_b (node_b),
		.st     (st),
		.node   (node),
		.status (status),
		.last   (last),
		.strobe (strobe)
	);

	// An edge transfer yields one final result in the next cycle
	a_add_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_ADD)) |=> (strobe && last))
		else $error("edge transfer gave no final result");

	// Status results always close their item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status != STAT_VISIT)) |-> last)
		else $error("status result without last");

	// The final result leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("busy after final result");

	// A non-final result means the traversal is still running
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("traversal stopped before final result");

endmodule

`default_nettype wire

[rtl/core/gbft_ctrl.sv]
`default_nettype none

module gbft_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [1:0]               func,
	input  gbft_pkg::dp_status_t     st,
	output gbft_pkg::cmd_t           cmd,
	output logic                     busy
);
	import gbft_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (func)
						FUNC_ADD:   cmd.add = 1'b1;
						FUNC_CLEAR: cmd.clear = 1'b1;
						FUNC_TRAVERSE: begin
							if (st.start_ok) begin
								cmd.trav_start = 1'b1;
								state_d        = ST_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = st.queue_empty ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[rtl/core/gbft_datapath.sv]
`default_nettype none

module gbft_datapath (
	input  wire                             clk,
	input  wire                             arst_n,
	input  gbft_pkg::cmd_t                  cmd,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_a,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_b,
	output gbft_pkg::dp_status_t            st,
	output logic [gbft_pkg::NODE_W-1:0]     node,
	output logic [gbft_pkg::STAT_W-1:0]     status,
	output logic                            last,
	output logic                            strobe
);
	import gbft_pkg::*;

	// Edge table: both endpoints of one edge in one word
	logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
	logic [2*NODE_W-1:0] edge_rd_s1;
	logic                edge_vld_s1;
	logic [EC_W-1:0]     edge_count_q;
	logic [EC_W-1:0]     idx_q;

	// Pending queue and its pointers
	logic [NODE_W-1:0]   queue_mem [MAX_NODES];
	logic [NODE_W-1:0]   queue_rd_q;
	logic [QP_W-1:0]     head_q;
	logic [QP_W-1:0]     tail_q;

	logic [MAX_NODES-1:0] visited_q;
	logic [NODE_W-1:0]    u_q;

	logic [NODE_W-1:0]   node_q;
	logic [STAT_W-1:0]   status_q;
	logic                last_q;
	logic                strobe_q;

	logic                add_ok;
	logic                issue;
	logic [NODE_W-1:0]   e_one;
	logic [NODE_W-1:0]   e_two;
	logic                hit;
	logic [NODE_W-1:0]   v;
	logic                reach;

	// Edge admission and scan issue
	assign add_ok = (edge_count_q < EC_W'(MAX_EDGES))
		&& ((NODE_W+1)'(node_a) < (NODE_W+1)'(MAX_NODES))
		&& ((NODE_W+1)'(node_b) < (NODE_W+1)'(MAX_NODES));
	assign issue = cmd.scan && (idx_q < edge_count_q);

	// Pick the far end of an edge that touches the current node
	assign e_one = edge_rd_s1[2*NODE_W-1:NODE_W];
	assign e_two = edge_rd_s1[NODE_W-1:0];
	always_comb begin
		hit = 1'b0;
		v   = e_two;
		if (e_one == u_q) begin
			hit = 1'b1;
			v   = e_two;
		end else if (e_two == u_q) begin
			hit = 1'b1;
			v   = e_one;
		end
	end
	assign reach = cmd.scan && edge_vld_s1 && hit
		&& ((NODE_W+1)'(v) < (NODE_W+1)'(MAX_NODES))
		&& !visited_q[v[NI_W-1:0]]
		&& (tail_q < QP_W'(MAX_NODES));

	// Memories: edge write on add, edge read during scan, queue write/read
	always_ff @(posedge clk) begin
		if (cmd.add && add_ok) begin
			edge_mem[edge_count_q[EI_W-1:0]] <= {node_a, node_b};
		end
		if (issue) begin
			edge_rd_s1 <= edge_mem[idx_q[EI_W-1:0]];
		end
		if (cmd.trav_start) begin
			queue_mem[0] <= node_a;
		end else if (reach) begin
			queue_mem[tail_q[NI_W-1:0]] <= v;
		end
		if (cmd.fetch) begin
			queue_rd_q <= queue_mem[head_q[NI_W-1:0]];
		end
	end

	// Control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			idx_q        <= '0;
			edge_vld_s1  <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.add || cmd.clear || cmd.emit;
			if (cmd.add && add_ok) begin
				edge_count_q <= edge_count_q + EC_W'(1);
			end
			if (cmd.clear) begin
				visited_q <= '0;
			end else if (cmd.trav_start) begin
				visited_q[node_a[NI_W-1:0]] <= 1'b1;
			end else if (reach) begin
				visited_q[v[NI_W-1:0]] <= 1'b1;
			end
			if (cmd.trav_start) begin
				head_q <= '0;
				tail_q <= QP_W'(1);
			end else begin
				if (reach) begin
					tail_q <= tail_q + QP_W'(1);
				end
				if (cmd.fetch) begin
					head_q <= head_q + QP_W'(1);
				end
			end
			if (cmd.load) begin
				idx_q       <= '0;
				edge_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				edge_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + EC_W'(1);
				end
			end
		end
	end

	// Current node and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= queue_rd_q;
		end
		if (cmd.add) begin
			node_q   <= '0;
			status_q <= add_ok ? STAT_STORED : STAT_FULL;
			last_q   <= 1'b1;
		end else if (cmd.clear) begin
			node_q   <= '0;
			status_q <= STAT_CLEARED;
			last_q   <= 1'b1;
		end else if (cmd.emit) begin
			node_q   <= u_q;
			status_q <= STAT_VISIT;
			last_q   <= (head_q == tail_q);
		end
	end

	assign st.start_ok    = ((NODE_W+1)'(node_a) < (NODE_W+1)'(MAX_NODES));
	assign st.scan_done   = (idx_q == edge_count_q) && !edge_vld_s1;
	assign st.queue_empty = (head_q == tail_q);

	assign node   = node_q;
	assign status = status_q;
	assign last   = last_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

[tb/gbft_result_checker.sv]
`timescale 1ns / 100ps

module gbft_result_checker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire                             busy,
	input  wire  [gbft_pkg::FUNC_W-1:0]     func,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_a,
	input  wire  [gbft_pkg::NODE_W-1:0]     node_b,
	input  wire                             strobe,
	input  wire  [gbft_pkg::NODE_W-1:0]     node,
	input  wire  [gbft_pkg::STAT_W-1:0]     status,
	input  wire                             last,
	output int                              fail_count,
	output int                              pending_count
);

	import gbft_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		status_t           status;
		logic              last;
	} traversal_result_t;

	// Mirror of the graph held by the block
	logic [NODE_W-1:0]    edge_from [MAX_EDGES];
	logic [NODE_W-1:0]    edge_to   [MAX_EDGES];
	logic [EC_W-1:0]      edges_held;
	logic [MAX_NODES-1:0] marked;

	// Breadth-first order of the traversal being worked out
	logic [NODE_W-1:0]    bfs_order [MAX_NODES];
	logic [QP_W-1:0]      bfs_head;
	logic [QP_W-1:0]      bfs_tail;

	traversal_result_t    expected_results [$];
	traversal_result_t    oldest;
	int                   fail_total;

	// Append one predicted result behind the older ones
	task automatic expect_result(input traversal_result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// Queue a neighbour that has not been reached yet
	task automatic reach_node(input logic [NODE_W-1:0] v);
		if (!marked[v] && bfs_tail < MAX_NODES) begin
			marked[v] = 1'b1;
			bfs_order[bfs_tail] = v;
			bfs_tail++;
		end
	endtask

	// Work out every result that one command transfer causes
	task automatic predict_command(
		input logic [FUNC_W-1:0] f,
		input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b
	);
		traversal_result_t res;
		logic [NODE_W-1:0] u;
		int i;
		res = '0;
		case (func_t'(f))
			FUNC_ADD: begin
				if (edges_held >= MAX_EDGES || a >= MAX_NODES || b >= MAX_NODES) begin
					res.status = STAT_FULL;
				end else begin
					edge_from[edges_held] = a;
					edge_to[edges_held] = b;
					edges_held++;
					res.status = STAT_STORED;
				end
				res.last = 1'b1;
				expect_result(res);
			end
			FUNC_CLEAR: begin
				marked = '0;
				res.status = STAT_CLEARED;
				res.last = 1'b1;
				expect_result(res);
			end
			FUNC_TRAVERSE: begin
				// Start node is emitted and marked whatever its mark was
				marked[a] = 1'b1;
				bfs_order[0] = a;
				bfs_head = '0;
				bfs_tail = 1;
				while (bfs_head < bfs_tail) begin
					u = bfs_order[bfs_head];
					bfs_head++;
					for (i = 0; i < edges_held; i++) begin
						if (edge_from[i] == u)
							reach_node(edge_to[i]);
						if (edge_to[i] == u)
							reach_node(edge_from[i]);
					end
					res.node = u;
					res.status = STAT_VISIT;
					res.last = (bfs_head == bfs_tail);
					expect_result(res);
				end
			end
			default: begin
				// unused code: no result
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_held = '0;
			marked = '0;
			expected_results.delete();
			fail_total = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			// Compare first: a result always belongs to an older transfer
			if (strobe) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: node %0d status %0d last %0d",
						node, status, last);
					fail_total++;
				end else begin
					oldest = expected_results.pop_front();
					if (node !== oldest.node) begin
						$error("node mismatch: expected %0d, actual %0d", oldest.node, node);
						fail_total++;
					end
					if (status !== oldest.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							oldest.status, status);
						fail_total++;
					end
					if (last !== oldest.last) begin
						$error("last mismatch: expected %0d, actual %0d", oldest.last, last);
						fail_total++;
					end
				end
			end
			if (start && !busy)
				predict_command(func, node_a, node_b);
			pending_count <= expected_results.size();
			fail_count <= fail_total;
		end
	end

endmodule

[tb/graph_breadth_first_traversal_unit_test.sv]
`timescale 1ns / 100ps

module graph_breadth_first_traversal_unit_test;

	import gbft_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// Longest quiet stretch is one edge table rescan; allow many times over
	localparam int STALL_LIMIT = 16 * (MAX_EDGES + 8);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [FUNC_W-1:0] func = FUNC_ADD;
	logic [NODE_W-1:0] node_a = '0;
	logic [NODE_W-1:0] node_b = '0;
	logic              busy;
	logic              strobe;
	logic [NODE_W-1:0] node;
	logic [STAT_W-1:0] status;
	logic              last;

	int fail_count;
	int pending_count;
	int sender_idle_pct = 0;
	int stall_cycles = 0;

	graph_breadth_first_traversal_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.func   (func),
		.node_a (node_a),
		.node_b (node_b),
		.strobe (strobe),
		.node   (node),
		.status (status),
		.last   (last)
	);

	gbft_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.node_a        (node_a),
		.node_b        (node_b),
		.strobe        (strobe),
		.node          (node),
		.status        (status),
		.last          (last),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Drive one command and hold it until the transfer
	task automatic send_command(
		input logic [FUNC_W-1:0] f,
		input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b
	);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Bias towards a few nodes so that the graph gets connected
	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(3) != 0)
			return NODE_W'($urandom_range(11));
		return NODE_W'($urandom_range(MAX_NODES - 1));
	endfunction

	task automatic run_random_phase(input int idle_pct, input int items);
		int n;
		int pick;
		sender_idle_pct = idle_pct;
		for (n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				send_command(FUNC_ADD, pick_node(), pick_node());
			else if (pick < 76)
				send_command(FUNC_TRAVERSE, pick_node(), NODE_W'($urandom));
			else if (pick < 92)
				send_command(FUNC_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
			else
				send_command(FUNC_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty graph, extremes, self loop, marked start, unused code
		send_command(FUNC_CLEAR, 6'd0, 6'd0);
		send_command(FUNC_TRAVERSE, 6'd0, 6'd63);
		send_command(FUNC_ADD, 6'd0, 6'd63);
		send_command(FUNC_ADD, 6'd63, 6'd5);
		send_command(FUNC_ADD, 6'd5, 6'd5);
		send_command(FUNC_ADD, 6'd0, 6'd1);
		send_command(FUNC_ADD, 6'd1, 6'd63);
		send_command(FUNC_TRAVERSE, 6'd0, 6'd0);
		send_command(FUNC_TRAVERSE, 6'd63, 6'd0);
		send_command(FUNC_UNUSED, 6'd63, 6'd63);
		send_command(FUNC_CLEAR, 6'd63, 6'd63);
		send_command(FUNC_TRAVERSE, 6'd5, 6'd0);
		send_command(FUNC_ADD, 6'd42, 6'd21);
		send_command(FUNC_ADD, 6'd21, 6'd42);
		send_command(FUNC_ADD, 6'd42, 6'd7);
		send_command(FUNC_TRAVERSE, 6'd21, 6'd42);
		send_command(FUNC_TRAVERSE, 6'd42, 6'd21);
		send_command(FUNC_CLEAR, 6'd0, 6'd0);
		send_command(FUNC_TRAVERSE, 6'd42, 6'd0);
		send_command(FUNC_TRAVERSE, 6'd7, 6'd0);
		send_command(FUNC_TRAVERSE, 6'd30, 6'd0);

		// Random: light gaps, heavy gaps, then back to back
		run_random_phase(9, 26);
		run_random_phase(84, 25);
		run_random_phase(0, 25);

		// Sweep the graph from a fresh set of marks
		sender_idle_pct = 9;
		send_command(FUNC_CLEAR, 6'd0, 6'd0);
		send_command(FUNC_TRAVERSE, NODE_W'($urandom), 6'd0);
		send_command(FUNC_TRAVERSE, 6'd63, 6'd0);
		start <= 1'b0;

		// Drain outstanding results, then watch for strays
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (MAX_EDGES + 16) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[graph_breadth_first_traversal_unit.f]
rtl/core/gbft_pkg.sv
rtl/core/gbft_ctrl.sv
rtl/core/gbft_datapath.sv
rtl/core/graph_breadth_first_traversal_unit.sv
tb/gbft_result_checker.sv
tb/graph_breadth_first_traversal_unit_test.sv
